### rtl/core/wqwr_pkg.sv
package wqwr_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_WAKE = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_BLOCKED = 2'd2,
    ST_POP_EMPTY   = 2'd3
  } status_e;

endpackage

### rtl/core/wqwr_if.sv
interface wqwr_in_if #(
  parameter int unsigned TASK_ID_BITS = 8,
  parameter int unsigned REASON_BITS  = 4
) ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [TASK_ID_BITS-1:0] task_id;
  logic [REASON_BITS-1:0]  task_reason;
  logic                    task_blocked;
  logic [REASON_BITS-1:0]  wake_reason;

  modport source (
    output valid, operation, task_id, task_reason, task_blocked, wake_reason,
    input  ready
  );
  modport sink (
    input  valid, operation, task_id, task_reason, task_blocked, wake_reason,
    output ready
  );
endinterface

interface wqwr_out_if #(
  parameter int unsigned TASK_ID_BITS = 8,
  parameter int unsigned OCC_BITS     = 5
) ();
  logic                    valid;
  logic                    ready;
  logic [TASK_ID_BITS-1:0] out_task;
  logic                    task_valid;
  logic [1:0]              status;
  logic [OCC_BITS-1:0]     occupancy;
  logic                    last;

  modport source (
    output valid, out_task, task_valid, status, occupancy, last,
    input  ready
  );
  modport sink (
    input  valid, out_task, task_valid, status, occupancy, last,
    output ready
  );
endinterface

### rtl/core/wqwr_mem.sv
module wqwr_mem #(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned WIDTH   = 12,
  parameter int unsigned ADDR_W  = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/wqwr_ctrl.sv
module wqwr_ctrl #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned TASK_ID_BITS = 8,
  parameter int unsigned REASON_BITS  = 4,
  parameter int unsigned PTR_W        = 4,
  parameter int unsigned CNT_W        = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input item
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               op_i,
  input  logic [TASK_ID_BITS-1:0]  task_id_i,
  input  logic [REASON_BITS-1:0]   task_reason_i,
  input  logic                     task_blocked_i,
  input  logic [REASON_BITS-1:0]   wake_reason_i,
  // result to output register
  input  logic                     out_free_i,
  output logic                     emit_o,
  output logic [TASK_ID_BITS-1:0]  res_task_o,
  output logic                     res_task_valid_o,
  output wqwr_pkg::status_e        res_status_o,
  output logic [CNT_W-1:0]         res_occ_o,
  output logic                     res_last_o
);

  localparam int unsigned EW = TASK_ID_BITS + REASON_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_WAKE = 4'b0100,
    S_WEND = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [PTR_W-1:0]        ins_q, ins_d;
  logic [PTR_W-1:0]        rem_q, rem_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        scan_q, scan_d;
  logic [REASON_BITS-1:0]  wreason_q, wreason_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [TASK_ID_BITS-1:0] pend_task_q, pend_task_d;
  logic [CNT_W-1:0]        pend_occ_q, pend_occ_d;

  logic                    we;
  logic [EW-1:0]           wdata;
  logic [EW-1:0]           rdata;
  logic                    accept;
  logic                    match;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  wqwr_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (EW),
    .ADDR_W (PTR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ins_q),
    .wdata_i (wdata),
    .raddr_i (rem_d),
    .rdata_o (rdata)
  );

  assign match = (rdata[EW-1:TASK_ID_BITS] == wreason_q);

  always_comb begin
    state_d          = state_q;
    ins_d            = ins_q;
    rem_d            = rem_q;
    count_d          = count_q;
    scan_d           = scan_q;
    wreason_d        = wreason_q;
    pend_valid_d     = pend_valid_q;
    pend_task_d      = pend_task_q;
    pend_occ_d       = pend_occ_q;
    we               = 1'b0;
    wdata            = rdata;
    emit_o           = 1'b0;
    res_task_o       = '0;
    res_task_valid_o = 1'b0;
    res_status_o     = wqwr_pkg::ST_OK;
    res_occ_o        = count_q;
    res_last_o       = 1'b0;
    in_ready_o       = (state_q == S_IDLE) && out_free_i;
    accept           = in_valid_i && in_ready_o;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (wqwr_pkg::op_e'(op_i))
            wqwr_pkg::OP_PUSH: begin
              emit_o     = 1'b1;
              res_last_o = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                res_status_o = wqwr_pkg::ST_FULL;
              end else if (!task_blocked_i) begin
                res_status_o = wqwr_pkg::ST_NOT_BLOCKED;
              end else begin
                we      = 1'b1;
                wdata   = {task_reason_i, task_id_i};
                ins_d   = ptr_inc(ins_q);
                count_d = count_q + 1'b1;
              end
              res_occ_o = count_d;
            end
            wqwr_pkg::OP_POP: begin
              if (count_q == '0) begin
                emit_o       = 1'b1;
                res_status_o = wqwr_pkg::ST_POP_EMPTY;
                res_occ_o    = '0;
                res_last_o   = 1'b1;
              end else begin
                state_d = S_POP;
              end
            end
            wqwr_pkg::OP_WAKE: begin
              if (count_q != '0) begin
                wreason_d = wake_reason_i;
                scan_d    = count_q;
                state_d   = S_WAKE;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (out_free_i) begin
          emit_o           = 1'b1;
          res_task_o       = rdata[TASK_ID_BITS-1:0];
          res_task_valid_o = 1'b1;
          res_occ_o        = count_q - 1'b1;
          res_last_o       = 1'b1;
          rem_d            = ptr_inc(rem_q);
          count_d          = count_q - 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_WAKE: begin
        if (match) begin
          // flush the held release first; wait while the output is busy
          if (!pend_valid_q || out_free_i) begin
            if (pend_valid_q) begin
              emit_o           = 1'b1;
              res_task_o       = pend_task_q;
              res_task_valid_o = 1'b1;
              res_occ_o        = pend_occ_q;
            end
            pend_valid_d = 1'b1;
            pend_task_d  = rdata[TASK_ID_BITS-1:0];
            pend_occ_d   = count_q - 1'b1;
            count_d      = count_q - 1'b1;
            rem_d        = ptr_inc(rem_q);
            scan_d       = scan_q - 1'b1;
            if (scan_q == CNT_W'(1)) begin
              state_d = S_WEND;
            end
          end
        end else begin
          // keep: requeue at the tail, order preserved
          we     = 1'b1;
          ins_d  = ptr_inc(ins_q);
          rem_d  = ptr_inc(rem_q);
          scan_d = scan_q - 1'b1;
          if (scan_q == CNT_W'(1)) begin
            state_d = S_WEND;
          end
        end
      end
      S_WEND: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free_i) begin
          emit_o           = 1'b1;
          res_task_o       = pend_task_q;
          res_task_valid_o = 1'b1;
          res_occ_o        = pend_occ_q;
          res_last_o       = 1'b1;
          pend_valid_d     = 1'b0;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ins_q        <= '0;
      rem_q        <= '0;
      count_q      <= '0;
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ins_q        <= ins_d;
      rem_q        <= rem_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wreason_q   <= wreason_d;
    pend_task_q <= pend_task_d;
    pend_occ_q  <= pend_occ_d;
  end

endmodule

### rtl/core/wait_queue_wake_by_reason_core.sv
// Wait queue of task identifiers with release by wait reason. Up to DEPTH
// tasks are held oldest first in a single-port-read memory, each with the
// reason it was pushed under. Results appear on the out channel in input
// order, the final one of each item flagged by last. A push always returns
// one status result; a pop reads the memory before returning the oldest
// task. A wakeup has the sequencer walk the queue one entry per cycle
// through the memory read port, unless a busy output stalls the walk,
// requeueing entries whose reason differs and releasing the rest. A wakeup
// that matches nothing returns no result. Each release is held in a pending
// register until the next one or the end of the walk, so that the last one
// can be marked. The input is not ready while an item is in progress or the
// output is busy. The store needs no clearing after reset.
module wait_queue_wake_by_reason_core #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned TASK_ID_BITS = 8,
  parameter int unsigned REASON_BITS  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wqwr_in_if.sink     in_i,
  wqwr_out_if.source  out_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                    out_free;
  logic                    emit;
  logic [TASK_ID_BITS-1:0] res_task;
  logic                    res_task_valid;
  wqwr_pkg::status_e       res_status;
  logic [CNT_W-1:0]        res_occ;
  logic                    res_last;

  // output register
  logic                    oval_q;
  logic [TASK_ID_BITS-1:0] otask_q;
  logic                    otvalid_q;
  wqwr_pkg::status_e       ostatus_q;
  logic [CNT_W-1:0]        oocc_q;
  logic                    olast_q;

  // free when empty or drained this cycle
  assign out_free = !oval_q || out_o.ready;

  wqwr_ctrl #(
    .DEPTH        (DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS),
    .REASON_BITS  (REASON_BITS),
    .PTR_W        (PTR_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .op_i             (in_i.operation),
    .task_id_i        (in_i.task_id),
    .task_reason_i    (in_i.task_reason),
    .task_blocked_i   (in_i.task_blocked),
    .wake_reason_i    (in_i.wake_reason),
    .out_free_i       (out_free),
    .emit_o           (emit),
    .res_task_o       (res_task),
    .res_task_valid_o (res_task_valid),
    .res_status_o     (res_status),
    .res_occ_o        (res_occ),
    .res_last_o       (res_last)
  );

  // Hold the item until taken; load a new one when free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (out_free) begin
      oval_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      otask_q   <= res_task;
      otvalid_q <= res_task_valid;
      ostatus_q <= res_status;
      oocc_q    <= res_occ;
      olast_q   <= res_last;
    end
  end

  assign out_o.valid      = oval_q;
  assign out_o.out_task   = otask_q;
  assign out_o.task_valid = otvalid_q;
  assign out_o.status     = ostatus_q;
  assign out_o.occupancy  = oocc_q;
  assign out_o.last       = olast_q;

endmodule
